// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/mtm_pkg.sv =====
package mtm_pkg;
  localparam int unsigned RecvDepth  = 16;
  localparam int unsigned SendDepth  = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned RIdxW = $clog2(RecvDepth);
  localparam int unsigned SIdxW = $clog2(SendDepth);
  localparam int unsigned RCntW = $clog2(RecvDepth + 1);
  localparam int unsigned SCntW = $clog2(SendDepth + 1);
  localparam int unsigned NResW = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    REQ_SEND = 2'd0,
    REQ_RECV = 2'd1,
    REQ_POLL = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FULL
  } state_e;

  typedef struct packed {
    logic [7:0]  comm_id;
    logic [9:0]  dest_rank;
    logic [9:0]  src_rank;
    logic [14:0] msg_tag;
  } key_t;

  typedef struct packed {
    logic [7:0]  msg_handle;
    logic [31:0] msg_bytes;
  } info_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  comm_id;
    logic [9:0]  dest_rank;
    logic [9:0]  src_rank;
    logic [14:0] msg_tag;
    logic [7:0]  msg_handle;
    logic [31:0] msg_bytes;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  recv_id;
    logic [7:0]  send_id;
    logic [31:0] copy_bytes;
    logic        last;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, append it if a send or receive and its queue is not full
    logic step;      // advance the receive scan pointer
    logic drop;      // remove the matched pair
    logic rst_scan;  // restart scan at the oldest receive
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic send_full;
    logic recv_full;
    logic scan_end;  // pointer past the last receive
    logic hit;       // current receive is of the item's pair and has a matching send
  } sts_t;
endpackage

// ===== rtl/mtm_if.sv =====
interface mtm_req_if;
  import mtm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mtm_rsp_if;
  import mtm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mtm_datapath.sv =====
`include "assert_macros.svh"
module mtm_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mtm_pkg::req_t req_i,
  input  mtm_pkg::cmd_t cmd_i,
  output mtm_pkg::sts_t sts_o,
  output mtm_pkg::rsp_t hit_o
);
  import mtm_pkg::*;

  key_t  rkey_q [RecvDepth];
  info_t rinfo_q[RecvDepth];
  key_t  skey_q [SendDepth];
  info_t sinfo_q[SendDepth];
  logic [RCntW-1:0] rcnt_q, rcnt_d;
  logic [SCntW-1:0] scnt_q, scnt_d;
  logic [RCntW-1:0] ptr_q, ptr_d;
  logic [17:0] pair_q;

  logic [RIdxW-1:0] ridx;
  logic [SendDepth-1:0] smatch;
  logic [SIdxW-1:0] sidx;
  logic shit;
  logic rpair;
  key_t  cur_key;
  info_t cur_rinfo, cur_sinfo;
  key_t  in_key;
  info_t in_info;

  assign in_key  = '{req_i.comm_id, req_i.dest_rank, req_i.src_rank, req_i.msg_tag};
  assign in_info = '{req_i.msg_handle, req_i.msg_bytes};
  assign ridx = ptr_q[RIdxW-1:0];
  assign cur_key = rkey_q[ridx];
  assign cur_rinfo = rinfo_q[ridx];
  assign rpair = ({cur_key.comm_id, cur_key.dest_rank} == pair_q);

  // Parallel compare of the current receive against every pending send.
  always_comb begin
    for (int j = 0; j < SendDepth; j++) begin
      smatch[j] = (SCntW'(j) < scnt_q) && (skey_q[j] == cur_key);
    end
  end

  // Oldest matching send wins.
  always_comb begin
    sidx = '0;
    shit = 1'b0;
    for (int j = SendDepth - 1; j >= 0; j--) begin
      if (smatch[j]) begin
        sidx = SIdxW'(j);
        shit = 1'b1;
      end
    end
  end
  assign cur_sinfo = sinfo_q[sidx];

  assign sts_o.send_full = (scnt_q == SCntW'(SendDepth));
  assign sts_o.recv_full = (rcnt_q == RCntW'(RecvDepth));
  assign sts_o.scan_end  = (ptr_q >= rcnt_q);
  assign sts_o.hit       = (ptr_q < rcnt_q) && rpair && shit;

  assign hit_o.status     = 1'b0;
  assign hit_o.recv_id    = cur_rinfo.msg_handle;
  assign hit_o.send_id    = cur_sinfo.msg_handle;
  assign hit_o.copy_bytes = (cur_sinfo.msg_bytes < cur_rinfo.msg_bytes) ?
                            cur_sinfo.msg_bytes : cur_rinfo.msg_bytes;
  assign hit_o.last       = 1'b0;

  always_comb begin
    rcnt_d = rcnt_q;
    scnt_d = scnt_q;
    ptr_d  = ptr_q;
    if (cmd_i.load) begin
      if (req_i.req_type == REQ_SEND && !sts_o.send_full) scnt_d = scnt_q + 1'b1;
      if (req_i.req_type == REQ_RECV && !sts_o.recv_full) rcnt_d = rcnt_q + 1'b1;
    end
    if (cmd_i.drop) begin
      rcnt_d = rcnt_q - 1'b1;
      scnt_d = scnt_q - 1'b1;
    end
    if (cmd_i.step) ptr_d = ptr_q + 1'b1;
    if (cmd_i.rst_scan) ptr_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
      scnt_q <= '0;
      ptr_q  <= '0;
    end else begin
      rcnt_q <= rcnt_d;
      scnt_q <= scnt_d;
      ptr_q  <= ptr_d;
    end
  end

  // Stores: append at the count, shift down above a removed entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pair_q <= {req_i.comm_id, req_i.dest_rank};
      if (req_i.req_type == REQ_SEND && !sts_o.send_full) begin
        skey_q[scnt_q[SIdxW-1:0]]  <= in_key;
        sinfo_q[scnt_q[SIdxW-1:0]] <= in_info;
      end
      if (req_i.req_type == REQ_RECV && !sts_o.recv_full) begin
        rkey_q[rcnt_q[RIdxW-1:0]]  <= in_key;
        rinfo_q[rcnt_q[RIdxW-1:0]] <= in_info;
      end
    end
    if (cmd_i.drop) begin
      for (int j = 0; j < RecvDepth - 1; j++) begin
        if (RIdxW'(j) >= ridx) begin
          rkey_q[j]  <= rkey_q[j+1];
          rinfo_q[j] <= rinfo_q[j+1];
        end
      end
      for (int j = 0; j < SendDepth - 1; j++) begin
        if (SIdxW'(j) >= sidx) begin
          skey_q[j]  <= skey_q[j+1];
          sinfo_q[j] <= sinfo_q[j+1];
        end
      end
    end
  end

  `ASSERT_NEVER(a_drop_needs_hit, clk_i, rst_ni, cmd_i.drop && !sts_o.hit)
  `ASSERT_NEVER(a_rcnt_range, clk_i, rst_ni, rcnt_q > RCntW'(RecvDepth))
  `ASSERT_NEVER(a_scnt_range, clk_i, rst_ni, scnt_q > SCntW'(SendDepth))
endmodule

// ===== rtl/mtm_ctrl.sv =====
`include "assert_macros.svh"
module mtm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    req_type_i,
  input  mtm_pkg::sts_t sts_i,
  input  mtm_pkg::rsp_t hit_i,
  output mtm_pkg::cmd_t cmd_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mtm_pkg::rsp_t out_o
);
  import mtm_pkg::*;

  state_e state_q, state_d;
  rsp_t pend_q, pend_d;       // found match, held until the next one shows whether it is last
  logic pend_v_q, pend_v_d;
  rsp_t obuf_q, obuf_d;
  logic ov_q, ov_d;
  logic [NResW-1:0] nres_q, nres_d;
  logic flush;

  assign out_valid_o = ov_q;
  assign out_o = obuf_q;

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    obuf_d   = obuf_q;
    ov_d     = ov_q && !out_ready_i;
    nres_d   = nres_q;
    cmd_o    = '0;
    in_ready_o = 1'b0;
    flush = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.rst_scan = 1'b1;
          nres_d = '0;
          pend_v_d = 1'b0;
          priority if (req_type_i == REQ_SEND) begin
            if (sts_i.send_full) state_d = ST_FULL;
          end else if (req_type_i == REQ_RECV) begin
            state_d = sts_i.recv_full ? ST_FULL : ST_SCAN;
          end else if (req_type_i == REQ_POLL) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_FULL: begin
        if (!ov_d) begin
          obuf_d = '{status: 1'b1, recv_id: '0, send_id: '0, copy_bytes: '0, last: 1'b1};
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_end || nres_q == NResW'(MaxResults)) begin
          flush = 1'b1;
        end else if (sts_i.hit) begin
          // A pending match must leave before a new one is latched.
          if (!pend_v_q || !ov_d) begin
            if (pend_v_q) begin
              obuf_d = pend_q;
              ov_d = 1'b1;
            end
            pend_d = hit_i;
            pend_v_d = 1'b1;
            cmd_o.drop = 1'b1;
            nres_d = nres_q + 1'b1;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
        if (flush) begin
          if (!pend_v_q) begin
            state_d = ST_IDLE;
          end else if (!ov_d) begin
            obuf_d = pend_q;
            obuf_d.last = 1'b1;
            ov_d = 1'b1;
            pend_v_d = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      nres_q   <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      nres_q   <= nres_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    obuf_q <= obuf_d;
  end

  `ASSERT_NEVER(a_pend_idle, clk_i, rst_ni, state_q == ST_IDLE && pend_v_q)
  `ASSERT_NEVER(a_nres_max, clk_i, rst_ni, nres_q > NResW'(MaxResults))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, ov_q && !out_ready_i |=> ov_q && $stable(obuf_q))
endmodule

// ===== rtl/message_tag_matcher_unit.sv =====
// Channel | Dir | Payload
// req     | in  | req_type comm_id dest_rank src_rank msg_tag msg_handle msg_bytes
// rsp     | out | status recv_id send_id copy_bytes last
//
// A send only loads; a rejected post then returns a reject beat. A receive or poll
// loads, visits the posted receives (one receive per cycle while the output does not
// stall, against a parallel compare of all pending sends) and closes the pass.
// Reset (rst_ni, asynchronous, active low) empties both queues.
// A stalled output holds the pass; the last result of a pass leaves only when
// the output register is free, and a new item is taken in the cycle after.
module message_tag_matcher_unit (
  input logic clk_i,
  input logic rst_ni,
  mtm_req_if.sink   req_i,
  mtm_rsp_if.source rsp_o
);
  import mtm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rsp_t hit;

  // Datapath: the two queues, the scan pointer and the parallel send compare.
  mtm_datapath u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .hit_o (hit)
  );

  // Controller: sequences the match pass and owns the output register.
  mtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .req_type_i (req_i.data.req_type),
    .sts_i      (sts),
    .hit_i      (hit),
    .cmd_o      (cmd),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .out_o      (rsp_o.data)
  );
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for message_tag_matcher_unit.
// A driver pushes request beats from a queue that the stimulus process fills,
// and a monitor checks every response beat against a predictor that keeps its
// own copy of the pending-send and posted-receive queues.
module tb_top;
  import mtm_pkg::*;

  logic clk_i;
  logic rst_ni;

  mtm_req_if req_if ();
  mtm_rsp_if rsp_if ();

  message_tag_matcher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state: the two queues in arrival order.
  key_t  pred_recv_key[$];
  info_t pred_recv_info[$];
  key_t  pred_send_key[$];
  info_t pred_send_info[$];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  int n_errors = 0;
  int n_rsps   = 0;
  int n_matches = 0;
  int n_rejects = 0;
  int n_accepted = 0;
  int stall_cycles = 0;

  // A rejected post yields one beat with status and last set and all else zero.
  function automatic rsp_t reject_rsp();
    rsp_t r;
    r = '0;
    r.status = 1'b1;
    r.last = 1'b1;
    return r;
  endfunction

  // Walk the posted receives of the item's (comm, dest) pair, oldest first,
  // pairing each with the oldest send of identical key, up to MaxResults.
  task automatic run_match_pass(input key_t k);
    int i;
    int j;
    int n;
    bit found;
    rsp_t r;
    n = 0;
    i = 0;
    while (i < pred_recv_key.size() && n < MaxResults) begin
      found = 1'b0;
      if (pred_recv_key[i].comm_id == k.comm_id &&
          pred_recv_key[i].dest_rank == k.dest_rank) begin
        for (j = 0; j < pred_send_key.size(); j++) begin
          if (pred_send_key[j] == pred_recv_key[i]) begin
            r.status = 1'b0;
            r.recv_id = pred_recv_info[i].msg_handle;
            r.send_id = pred_send_info[j].msg_handle;
            r.copy_bytes = (pred_send_info[j].msg_bytes < pred_recv_info[i].msg_bytes) ?
                           pred_send_info[j].msg_bytes : pred_recv_info[i].msg_bytes;
            r.last = 1'b0;
            expected_rsps.push_back(r);
            pred_send_key.delete(j);
            pred_send_info.delete(j);
            pred_recv_key.delete(i);
            pred_recv_info.delete(i);
            n++;
            found = 1'b1;
            break;
          end
        end
      end
      if (!found) i++;
    end
    // Flag the final beat of this pass.
    if (n > 0) expected_rsps[expected_rsps.size() - 1].last = 1'b1;
  endtask

  task automatic predict_item(input req_t q);
    key_t k;
    info_t f;
    k = '{q.comm_id, q.dest_rank, q.src_rank, q.msg_tag};
    f = '{q.msg_handle, q.msg_bytes};
    case (req_e'(q.req_type))
      REQ_SEND: begin
        if (pred_send_key.size() >= SendDepth) begin
          expected_rsps.push_back(reject_rsp());
          n_rejects++;
        end else begin
          pred_send_key.push_back(k);
          pred_send_info.push_back(f);
        end
      end
      REQ_RECV: begin
        if (pred_recv_key.size() >= RecvDepth) begin
          expected_rsps.push_back(reject_rsp());
          n_rejects++;
        end else begin
          pred_recv_key.push_back(k);
          pred_recv_info.push_back(f);
          run_match_pass(k);
        end
      end
      REQ_POLL: begin
        run_match_pass(k);
      end
      default: begin
      end
    endcase
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_item(req_if.data);
        n_accepted++;
        void'(pending_reqs.pop_front());
      end
      // Decide the next beat from the queue as it stands after the pop above.
      if (req_if.valid && !req_if.ready) begin
        // A waiting beat stays on the bus unchanged until it is taken.
        req_if.valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.data <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(20, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls follow their own mode, switched now and then.
  int stall_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(63, 0) == 0) stall_mode <= $urandom_range(3, 0);
      case (stall_mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(3, 0) != 0);
        2: rsp_if.ready <= ($urandom_range(1, 0) != 0);
        default: rsp_if.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // Monitor: compare every response beat with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_rsps++;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response beat, actual %p", $time, rsp_if.data);
        n_errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (!want.status) n_matches++;
        if (rsp_if.data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_if.data.status);
          n_errors++;
        end
        if (rsp_if.data.recv_id !== want.recv_id) begin
          $display("%0t: recv_id expected %0d actual %0d", $time, want.recv_id,
                   rsp_if.data.recv_id);
          n_errors++;
        end
        if (rsp_if.data.send_id !== want.send_id) begin
          $display("%0t: send_id expected %0d actual %0d", $time, want.send_id,
                   rsp_if.data.send_id);
          n_errors++;
        end
        if (rsp_if.data.copy_bytes !== want.copy_bytes) begin
          $display("%0t: copy_bytes expected %0h actual %0h", $time, want.copy_bytes,
                   rsp_if.data.copy_bytes);
          n_errors++;
        end
        if (rsp_if.data.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last,
                   rsp_if.data.last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel.
  localparam int StallLimit = 20000;

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (rst_ni && (pending_reqs.size() > 0 || expected_rsps.size() > 0)) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("%0t: watchdog expired, %0d beats still expected", $time,
                 expected_rsps.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic req_t make_req(req_e t, logic [7:0] c, logic [9:0] d, logic [9:0] s,
                                    logic [14:0] g, logic [7:0] h, logic [31:0] b);
    req_t q;
    q.req_type = t;
    q.comm_id = c;
    q.dest_rank = d;
    q.src_rank = s;
    q.msg_tag = g;
    q.msg_handle = h;
    q.msg_bytes = b;
    return q;
  endfunction

  // Random item drawn from a small key space so that matches are common;
  // now and then a field takes a fully random value to exercise every bit.
  function automatic req_t rand_req(int unsigned send_pct, int unsigned recv_pct);
    req_t q;
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < send_pct) q.req_type = REQ_SEND;
    else if (r < send_pct + recv_pct) q.req_type = REQ_RECV;
    else if (r < 98) q.req_type = REQ_POLL;
    else q.req_type = REQ_NONE;
    q.comm_id = ($urandom_range(9, 0) == 0) ? 8'($urandom) : 8'($urandom_range(1, 0) * 8'hff);
    q.dest_rank = ($urandom_range(9, 0) == 0) ? 10'($urandom) : 10'($urandom_range(2, 0) * 511);
    q.src_rank = ($urandom_range(9, 0) == 0) ? 10'($urandom) : 10'($urandom_range(1, 0) * 10'h3ff);
    q.msg_tag = ($urandom_range(9, 0) == 0) ? 15'($urandom) : 15'($urandom_range(2, 0) * 15'h3fff);
    q.msg_handle = 8'($urandom);
    q.msg_bytes = ($urandom_range(3, 0) == 0) ? 32'($urandom_range(16, 0)) : 32'($urandom);
    return q;
  endfunction

  initial begin
    int i;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a basic match at the field extremes, a mismatch by tag,
    // an unused request code, a poll with nothing to do, and a late send
    // that a poll pairs with the stray receive so both queues end empty.
    pending_reqs.push_back(make_req(REQ_SEND, 8'hff, 10'h3ff, 10'h3ff, 15'h7fff, 8'hff,
                                    32'hffff_ffff));
    pending_reqs.push_back(make_req(REQ_RECV, 8'hff, 10'h3ff, 10'h3ff, 15'h7fff, 8'h00,
                                    32'h0000_0000));
    pending_reqs.push_back(make_req(REQ_SEND, 8'h00, 10'h000, 10'h000, 15'h0000, 8'h11, 32'd9));
    pending_reqs.push_back(make_req(REQ_RECV, 8'h00, 10'h000, 10'h000, 15'h0001, 8'h22, 32'd5));
    pending_reqs.push_back(make_req(REQ_NONE, 8'h00, 10'h000, 10'h000, 15'h0001, 8'h33, 32'd5));
    pending_reqs.push_back(make_req(REQ_POLL, 8'h00, 10'h000, 10'h000, 15'h0000, 8'h00, 32'd0));
    pending_reqs.push_back(make_req(REQ_RECV, 8'h00, 10'h000, 10'h000, 15'h0000, 8'h44, 32'd20));
    pending_reqs.push_back(make_req(REQ_SEND, 8'h00, 10'h000, 10'h000, 15'h0001, 8'h55, 32'd7));
    pending_reqs.push_back(make_req(REQ_POLL, 8'h00, 10'h000, 10'h000, 15'h0000, 8'h00, 32'd0));
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);

    // Fill the receive queue past its depth, then the send queue past its
    // depth, so both rejects show; a poll then finds sixteen matches at once.
    for (i = 0; i < RecvDepth; i++)
      pending_reqs.push_back(make_req(REQ_RECV, 8'h5a, 10'h155, 10'(i), 15'h2aaa,
                                      8'(8'h80 + i), 32'(50 + 10 * i)));
    pending_reqs.push_back(make_req(REQ_RECV, 8'h5a, 10'h155, 10'd0, 15'h2aaa, 8'h99, 32'd1));
    for (i = 0; i < SendDepth + 1; i++)
      pending_reqs.push_back(make_req(REQ_SEND, 8'h5a, 10'h155, 10'(i), 15'h2aaa, 8'(i),
                                      32'(100 + i)));
    pending_reqs.push_back(make_req(REQ_POLL, 8'h5a, 10'h155, 10'd0, 15'h0, 8'h0, 32'd0));
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);

    // Random traffic, send-heavy first and receive-heavy after.
    for (i = 0; i < 280; i++) begin
      if (i % 100 == 50) begin
        // Pause until every expected result has come, then resume.
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
      end
      if (i < 140) pending_reqs.push_back(rand_req(50, 35));
      else pending_reqs.push_back(rand_req(30, 55));
    end
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Run covered %0d accepted items, %0d response beats, %0d matches, %0d rejects.",
             n_accepted, n_rsps, n_matches, n_rejects);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mtm_pkg.sv
rtl/mtm_if.sv
rtl/mtm_datapath.sv
rtl/mtm_ctrl.sv
rtl/message_tag_matcher_unit.sv
verif/tb_top.sv
